// File: design/lru_key_value_cache_defines.svh
// Assertion macros for the LRU key-value cache.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define LKVC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define LKVC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> (prop)) else $error(msg);

`else

`define LKVC_ASSERT(label, prop, msg)
`define LKVC_ASSERT_NEXT(label, cond, prop, msg)

`endif

`endif

// File: design/lkvc_pkg.sv
// Package with widths, codes and constants of the LRU key-value cache.
`timescale 1ns / 1ps

package lkvc_pkg;

  // Default number of entries
  localparam int unsigned Entries = 16;

  // Field widths
  localparam int unsigned DataW = 32;
  localparam int unsigned CapW  = 5;

  // Capacity register after reset
  localparam logic [CapW-1:0] CapReset = 5'd16;

  // Read value returned by a get miss
  localparam logic [DataW-1:0] MissValue = 32'hFFFF_FFFF;

  // Read value returned by a set
  localparam logic [DataW-1:0] SetValue = 32'h0000_0000;

  // Operation codes
  typedef enum logic {
    FuncGet = 1'b0,
    FuncSet = 1'b1
  } func_e;

  // One request as held in the input register
  typedef struct packed {
    func_e            func;
    logic [DataW-1:0] key;
    logic [DataW-1:0] value;
  } req_t;

endpackage

// File: design/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
`timescale 1ns / 1ps
//
// Usage:
//   Requests enter on the in_* channel (valid/stall) as a get or a set with
//   a key and, for a set, a value. Each request yields one result on the
//   out_* channel: hit flag and read value (stored value or all ones on a get
//   miss, zero for a set).
//   The capacity register is written through cfg_we_i/cfg_wdata_i while the
//   cache is idle; zero acts as one, values above ENTRIES act as ENTRIES.
//   An accepted request is held in the input register, then the parallel key
//   compare, rank update and write of all entries run in one pass into the
//   result register. Throughput is one request per cycle while the receiver
//   does not stall, set by that single pass over all entries; the next
//   request sees the state the previous one left.
//   Reset clears all valid bits, the fill count and the valid flags of both
//   pipeline registers, and sets the capacity to 16.
//   When the receiver stalls, the result register holds, the input register
//   holds its request and in_stall_o rises until the result is taken.
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int unsigned ENTRIES = Entries
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Request channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    in_func_i,
  input  logic signed [DataW-1:0] in_key_i,
  input  logic signed [DataW-1:0] in_value_i,
  // Result channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    out_hit_o,
  output logic signed [DataW-1:0] out_read_value_o,
  // Capacity register
  input  logic                    cfg_we_i,
  input  logic [CapW-1:0]         cfg_wdata_i
);

  localparam int unsigned RankW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned FillW = $clog2(ENTRIES + 1);
  localparam int unsigned CmpW  = (FillW > CapW) ? FillW : CapW;

  // Entry state
  logic [DataW-1:0] keys_q   [ENTRIES];
  logic [DataW-1:0] values_q [ENTRIES];
  logic [RankW-1:0] rank_q   [ENTRIES];
  logic [RankW-1:0] rank_d   [ENTRIES];
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [CapW-1:0]  cap_q;

  // Pipeline registers
  req_t             req_q;
  logic             req_valid_q;
  logic             out_valid_q;
  logic             out_hit_q;
  logic [DataW-1:0] out_value_q;

  // Lookup and replacement signals
  logic [ENTRIES-1:0] match;
  logic               found;
  logic [RankW-1:0]   found_idx;
  logic [RankW-1:0]   found_rank;
  logic [DataW-1:0]   found_value;
  logic               full;
  logic [CmpW-1:0]    cap_lim;
  logic [FillW-1:0]   fill_m1;
  logic               evict_hit;
  logic [RankW-1:0]   evict_idx;
  logic               free_hit;
  logic [RankW-1:0]   free_idx;
  logic [RankW-1:0]   slot_idx;
  logic               advance;
  logic               do_promote;
  logic               do_insert;
  logic               res_hit;
  logic [DataW-1:0]   res_value;

  // Move the request into the pass when the result register can take it
  assign advance    = req_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = req_valid_q && !advance;

  // Compare the key against every valid entry
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_q[i] && (keys_q[i] == req_q.key);
    end
  end

  // Pick the first matching entry
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        found     = 1'b1;
        found_idx = RankW'(i);
      end
    end
  end

  assign found_rank  = rank_q[found_idx];
  assign found_value = values_q[found_idx];

  // Saturate the capacity into one to ENTRIES
  always_comb begin
    cap_lim = (cap_q == '0) ? CmpW'(1) : CmpW'(cap_q);
    if (cap_lim > CmpW'(ENTRIES)) begin
      cap_lim = CmpW'(ENTRIES);
    end
  end

  assign full    = CmpW'(fill_q) >= cap_lim;
  assign fill_m1 = fill_q - FillW'(1);

  // Find the oldest valid entry: ranks of valid entries are 0 to fill-1
  always_comb begin
    evict_hit = 1'b0;
    evict_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (rank_q[i] == fill_m1[RankW-1:0])) begin
        evict_hit = 1'b1;
        evict_idx = RankW'(i);
      end
    end
  end

  // Find the first free entry
  always_comb begin
    free_hit = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_hit = 1'b1;
        free_idx = RankW'(i);
      end
    end
  end

  assign slot_idx   = (full && evict_hit) ? evict_idx : free_idx;
  assign do_promote = advance && found;
  assign do_insert  = advance && !found && (req_q.func == FuncSet) &&
                      ((full && evict_hit) || free_hit);

  // Age the entries newer than the touched one, or all on an insert
  always_comb begin
    valid_d = valid_q;
    fill_d  = fill_q;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (do_promote) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i] && (RankW'(i) != found_idx) && (rank_q[i] < found_rank)) begin
          rank_d[i] = rank_q[i] + RankW'(1);
        end
      end
      rank_d[found_idx] = '0;
    end else if (do_insert) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i] && (RankW'(i) != slot_idx)) begin
          rank_d[i] = rank_q[i] + RankW'(1);
        end
      end
      rank_d[slot_idx]  = '0;
      valid_d[slot_idx] = 1'b1;
      if (!(full && evict_hit)) begin
        fill_d = fill_q + FillW'(1);
      end
    end
  end

  // Form the result
  always_comb begin
    res_hit = found;
    unique case (req_q.func)
      FuncGet: res_value = found ? found_value : MissValue;
      FuncSet: res_value = SetValue;
      default: res_value = SetValue;
    endcase
  end

  // Hold control state: valid bits, ranks, fill count, capacity, handshakes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      fill_q      <= '0;
      cap_q       <= CapReset;
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      fill_q  <= fill_d;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_o) begin
        req_valid_q <= 1'b1;
      end else if (advance) begin
        req_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the request and the result payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_q.func  <= func_e'(in_func_i);
      req_q.key   <= in_key_i;
      req_q.value <= in_value_i;
    end
    if (advance) begin
      out_hit_q   <= res_hit;
      out_value_q <= res_value;
    end
  end

  // Write the entry storage
  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      keys_q[slot_idx]   <= req_q.key;
      values_q[slot_idx] <= req_q.value;
    end else if (do_promote && (req_q.func == FuncSet)) begin
      values_q[found_idx] <= req_q.value;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_hit_o        = out_hit_q;
  assign out_read_value_o = out_value_q;

  // Checks on the cache state and the pipeline
  `LKVC_ASSERT(a_fill_matches_valid, fill_q == FillW'($countones(valid_q)), "fill count off")
  `LKVC_ASSERT(a_fill_in_range, CmpW'(fill_q) <= CmpW'(ENTRIES), "fill count too large")
  `LKVC_ASSERT(a_keys_unique, $onehot0(match), "key stored twice")
  `LKVC_ASSERT_NEXT(a_result_follows, advance, out_valid_q, "result not registered")
  `LKVC_ASSERT(a_stall_needs_request, !in_stall_o || req_valid_q, "stall without request")

endmodule

// File: test/testbench.sv
// Self-checking testbench for the LRU key-value cache.
`timescale 1ns / 1ps

module testbench;
  import lkvc_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int KeyPoolSize   = 24;
  localparam int ReportLimit   = 10;

  typedef struct {
    logic             hit;
    logic [DataW-1:0] read_value;
  } lookup_result_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic                    in_func_i   = 1'b0;
  logic signed [DataW-1:0] in_key_i    = '0;
  logic signed [DataW-1:0] in_value_i  = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic                    out_hit_o;
  logic signed [DataW-1:0] out_read_value_o;
  logic                    cfg_we_i    = 1'b0;
  logic [CapW-1:0]         cfg_wdata_i = '0;

  // Mirror of the cache contents and capacity
  logic [DataW-1:0] tag_mem  [Entries];
  logic [DataW-1:0] data_mem [Entries];
  logic             live     [Entries];
  int unsigned      age      [Entries];
  int unsigned      occupancy;
  logic [CapW-1:0]  cap_reg;

  lookup_result_t   pending_results[$];
  logic [DataW-1:0] key_pool[KeyPoolSize];
  int               mismatches  = 0;
  int               quiet_count = 0;
  int               send_idle_pct = 0;
  int               stall_pct     = 0;

  lru_key_value_cache uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_func_i        (in_func_i),
    .in_key_i         (in_key_i),
    .in_value_i       (in_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_hit_o        (out_hit_o),
    .out_read_value_o (out_read_value_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // Make slot s the newest; every live entry newer than it ages by one
  function automatic void promote_entry(input int s);
    int unsigned old_age;
    old_age = age[s];
    for (int i = 0; i < Entries; i++) begin
      if (live[i] && i != s && age[i] < old_age) age[i]++;
    end
    age[s] = 0;
  endfunction

  // Apply one request to the mirror and return the result it must produce
  function automatic lookup_result_t lookup_or_store(input func_e f,
                                                     input logic [DataW-1:0] k,
                                                     input logic [DataW-1:0] v);
    lookup_result_t res;
    int             found;
    int             slot;
    int unsigned    eff_cap;
    int unsigned    oldest;
    found = -1;
    slot  = -1;
    oldest = 0;
    for (int i = 0; i < Entries; i++) begin
      if (found < 0 && live[i] && tag_mem[i] == k) found = i;
    end
    res.hit = (found >= 0);
    if (f == FuncGet) begin
      if (found >= 0) begin
        res.read_value = data_mem[found];
        promote_entry(found);
      end else begin
        res.read_value = MissValue;
      end
      return res;
    end
    res.read_value = SetValue;
    if (found >= 0) begin
      data_mem[found] = v;
      promote_entry(found);
      return res;
    end
    // Saturate the capacity into 1..Entries
    eff_cap = (cap_reg == 0) ? 1 : ((cap_reg > Entries) ? Entries : cap_reg);
    // Evict the oldest live entry when full
    if (occupancy >= eff_cap) begin
      for (int i = 0; i < Entries; i++) begin
        if (live[i] && (slot < 0 || age[i] > oldest)) begin
          slot   = i;
          oldest = age[i];
        end
      end
      if (slot >= 0) begin
        live[slot] = 1'b0;
        occupancy--;
      end
    end
    if (slot < 0) begin
      for (int i = Entries - 1; i >= 0; i--) begin
        if (!live[i]) slot = i;
      end
    end
    if (slot >= 0) begin
      for (int i = 0; i < Entries; i++) begin
        if (live[i]) age[i]++;
      end
      tag_mem[slot]  = k;
      data_mem[slot] = v;
      live[slot]     = 1'b1;
      age[slot]      = 0;
      occupancy++;
    end
    return res;
  endfunction

  // Drive the receiver stall
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    lookup_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected result: hit %0b read_value %h", out_hit_o, out_read_value_o);
      end else begin
        want = pending_results.pop_front();
        if (out_hit_o !== want.hit || out_read_value_o !== want.read_value) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("mismatch: hit %0b read_value %h, expected hit %0b read_value %h",
                     out_hit_o, out_read_value_o, want.hit, want.read_value);
        end
      end
    end
  end

  // Abort when no request or result moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_count <= 0;
    end else if (rst_ni) begin
      quiet_count <= quiet_count + 1;
      if (quiet_count >= WatchdogLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Send one request; called and returns at a falling edge, valid left high
  task automatic send_request(input func_e f, input logic [DataW-1:0] k,
                              input logic [DataW-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      in_key_i   <= $urandom;
      in_value_i <= $urandom;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_func_i  <= f;
    in_key_i   <= k;
    in_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(lookup_or_store(f, k, v));
    @(negedge clk_i);
  endtask

  // Hold off requests until every pending result has arrived
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Write the capacity register while the cache is idle
  task automatic set_capacity(input logic [CapW-1:0] c);
    wait_until_drained();
    repeat (3) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg = c;
  endtask

  // Random gets and sets, mostly over the first span keys of the pool
  task automatic run_traffic(input int count, input int span);
    func_e            f;
    logic [DataW-1:0] k;
    logic [DataW-1:0] v;
    for (int n = 0; n < count; n++) begin
      f = func_e'($urandom_range(1));
      k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(span - 1)] : $urandom;
      case ($urandom_range(19))
        0:       v = 32'h8000_0000;
        1:       v = 32'h7FFF_FFFF;
        2:       v = 32'hFFFF_FFFF;
        3:       v = 32'h0000_0000;
        default: v = $urandom;
      endcase
      send_request(f, k, v);
    end
  endtask

  // Hits, misses, updates and eviction order at capacity two, with extreme keys
  task automatic test_basic_lookup();
    send_idle_pct = 0;
    stall_pct     = 0;
    set_capacity(5'd2);
    send_request(FuncGet, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(FuncSet, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(FuncSet, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(FuncGet, 32'h8000_0000, 32'h0000_0000);
    send_request(FuncSet, 32'h0000_0000, 32'h8000_0000);
    send_request(FuncGet, 32'h7FFF_FFFF, 32'h1234_5678);
    send_request(FuncGet, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(FuncSet, 32'h8000_0000, 32'h0000_0000);
    send_request(FuncGet, 32'h0000_0000, 32'h0000_0000);
    send_request(FuncSet, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Hit that returns all ones must still flag hit
    send_request(FuncGet, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(FuncGet, 32'h8000_0000, 32'h0000_0000);
  endtask

  // Zero capacity acts as one, and lies below the current fill
  task automatic test_capacity_floor();
    set_capacity(5'd0);
    send_request(FuncSet, 32'h0000_1234, 32'h5555_AAAA);
    send_request(FuncGet, 32'h0000_0000, 32'h0000_0000);
    send_request(FuncGet, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(FuncSet, 32'h0000_5678, 32'hAAAA_5555);
    send_request(FuncGet, 32'h0000_1234, 32'h0000_0000);
    send_request(FuncGet, 32'h0000_5678, 32'h0000_0000);
  endtask

  // Full capacity without idling, then shrink it below the fill under stalls
  task automatic test_capacity_shrink();
    send_idle_pct = 0;
    stall_pct     = 0;
    set_capacity(5'd16);
    run_traffic(190, 20);
    stall_pct = 70;
    set_capacity(5'd5);
    run_traffic(190, 9);
  endtask

  // Capacity above the entry count saturates, sender mostly idle
  task automatic test_capacity_ceiling();
    send_idle_pct = 70;
    stall_pct     = 0;
    set_capacity(5'd31);
    run_traffic(190, 24);
  endtask

  // One entry, light idling on both sides
  task automatic test_single_entry();
    send_idle_pct = 8;
    stall_pct     = 8;
    set_capacity(5'd1);
    run_traffic(190, 4);
  endtask

  // Mixed capacities with a full drain in the middle of the traffic
  task automatic test_random_capacity();
    send_idle_pct = 0;
    stall_pct     = 0;
    set_capacity(5'd17);
    run_traffic(95, 24);
    wait_until_drained();
    run_traffic(95, 24);
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = $urandom_range(1) ? 70 : 0;
      stall_pct     = $urandom_range(1) ? 70 : 0;
      set_capacity(5'($urandom_range(31)));
      run_traffic(48, 2 + $urandom_range(KeyPoolSize - 2));
    end
  endtask

  initial begin
    // Extreme keys lead the pool
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'h8000_0000;
    key_pool[2] = 32'h7FFF_FFFF;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < KeyPoolSize; i++) key_pool[i] = $urandom;
    for (int i = 0; i < Entries; i++) begin
      live[i] = 1'b0;
      age[i]  = 0;
    end
    occupancy = 0;
    cap_reg   = CapReset;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_lookup();
    test_capacity_floor();
    test_capacity_shrink();
    test_capacity_ceiling();
    test_single_entry();
    test_random_capacity();

    // Let the last results come out, then settle
    wait_until_drained();
    repeat (6) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/lkvc_pkg.sv
design/lru_key_value_cache.sv
test/testbench.sv
